// ===== hw/rtl/ssmd_pkg.sv =====
package ssmd_pkg;

  // Field widths fixed by the item formats.
  localparam int CHAR_W   = 8;
  localparam int OFFS_W   = 3;
  localparam int POS_W    = 8;
  localparam int MODE_W   = 3;
  localparam int SEG_W    = 8;
  localparam int EN_W     = 8;
  localparam int COUNT_W  = 4;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 4;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_DIGIT_COUNT    = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_COMMON_CATHODE = 1'b1;

  localparam logic [COUNT_W-1:0] DIGIT_COUNT_RESET = 4'd8;

  localparam logic [SEG_W-1:0] SEG_BLANK_ANODE   = 8'h00;
  localparam logic [SEG_W-1:0] SEG_BLANK_CATHODE = 8'hFF;
  localparam logic [EN_W-1:0]  EN_ALL_INACTIVE_ANODE = 8'hFF;

  typedef enum logic [MODE_W-1:0] {
    MODE_TICK    = 3'd0,
    MODE_WRITE   = 3'd1,
    MODE_SET_POS = 3'd2,
    MODE_CLEAR   = 3'd3,
    MODE_DOT     = 3'd4
  } mode_e_t;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [CHAR_W-1:0] char_code;
    logic [OFFS_W-1:0] char_offset;
    logic [POS_W-1:0]  new_position;
    logic              dot_on;
  } cmd_item_t;

  typedef struct packed {
    logic [SEG_W-1:0] segment_lines;
    logic [EN_W-1:0]  digit_enables;
  } drive_item_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_REDUCE_TICK,
    S_REDUCE_WRITE,
    S_TICK_LOAD,
    S_CLEAR,
    S_DOT,
    S_FINISH
  } ctrl_state_t;

  typedef struct packed {
    logic take_item;
    logic acc_load_scan;
    logic acc_load_write;
    logic acc_reduce;
    logic scan_from_acc;
    logic rd_en;
    logic rd_from_acc;
    logic latch_drive;
    logic wr_glyph;
    logic wr_dot;
    logic set_pos;
    logic clr_start;
    logic clr_step;
    logic load_out;
  } dp_cmd_t;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic n_zero;
    logic acc_ge_n;
    logic clr_done;
    logic out_free;
  } dp_stat_t;

  // Glyph table, segments a..g in bits 0..6 and the dot in bit 7.
  function automatic logic [SEG_W-1:0] glyph_of(input logic [CHAR_W-1:0] c);
    logic [SEG_W-1:0] g;
    case (c)
      8'h30:   g = 8'h3F; // '0'
      8'h31:   g = 8'h06;
      8'h32:   g = 8'h5B;
      8'h33:   g = 8'h4F;
      8'h34:   g = 8'h66;
      8'h35:   g = 8'h6D;
      8'h36:   g = 8'h7D;
      8'h37:   g = 8'h07;
      8'h38:   g = 8'h7F;
      8'h39:   g = 8'h6F; // '9'
      8'h41:   g = 8'h77; // 'A'
      8'h42:   g = 8'h7F; // 'B'
      8'h62:   g = 8'h7C; // 'b'
      8'h43:   g = 8'h39; // 'C'
      8'h63:   g = 8'h58; // 'c'
      8'h64:   g = 8'h5E; // 'd'
      8'h45:   g = 8'h79; // 'E'
      8'h46:   g = 8'h71; // 'F'
      8'h47:   g = 8'h3D; // 'G'
      8'h48:   g = 8'h76; // 'H'
      8'h68:   g = 8'h74; // 'h'
      8'h49:   g = 8'h06; // 'I'
      8'h69:   g = 8'h04; // 'i'
      8'h4A:   g = 8'h0F; // 'J'
      8'h6A:   g = 8'h0E; // 'j'
      8'h4C:   g = 8'h38; // 'L'
      8'h4F:   g = 8'h3F; // 'O'
      8'h6F:   g = 8'h5C; // 'o'
      8'h50:   g = 8'h73; // 'P'
      8'h53:   g = 8'h6D; // 'S'
      8'h54:   g = 8'h31; // 'T'
      8'h74:   g = 8'h78; // 't'
      8'h55:   g = 8'h3E; // 'U'
      8'h75:   g = 8'h1C; // 'u'
      8'h59:   g = 8'h66; // 'Y'
      8'h5A:   g = 8'h5B; // 'Z'
      8'h2E:   g = 8'h80; // '.'
      8'h2D:   g = 8'h40; // '-'
      8'h5F:   g = 8'h08; // '_'
      8'h3D:   g = 8'h48; // '='
      default: g = 8'h00;
    endcase
    return g;
  endfunction

endpackage

// ===== hw/rtl/ssmd_ctrl.sv =====
module ssmd_ctrl
  import ssmd_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     cmd_valid,
  output logic     cmd_stall,
  input  dp_stat_t stat,
  output dp_cmd_t  ctl
);

  ctrl_state_t state;
  ctrl_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign cmd_stall = (state != S_IDLE);

  always_comb begin
    state_next = state;
    ctl        = '0;
    case (state)
      S_IDLE: begin
        if (cmd_valid) begin
          ctl.take_item = 1'b1;
          state_next    = S_DECODE;
        end
      end
      S_DECODE: begin
        case (stat.mode)
          MODE_TICK: begin
            if (stat.n_zero) begin
              state_next = S_FINISH;
            end else begin
              ctl.acc_load_scan = 1'b1;
              state_next        = S_REDUCE_TICK;
            end
          end
          MODE_WRITE: begin
            if (stat.n_zero) begin
              state_next = S_FINISH;
            end else begin
              ctl.acc_load_write = 1'b1;
              state_next         = S_REDUCE_WRITE;
            end
          end
          MODE_SET_POS: begin
            ctl.set_pos = 1'b1;
            state_next  = S_FINISH;
          end
          MODE_CLEAR: begin
            ctl.clr_start = 1'b1;
            state_next    = S_CLEAR;
          end
          MODE_DOT: begin
            ctl.rd_en  = 1'b1;
            state_next = S_DOT;
          end
          default: begin
            state_next = S_FINISH;
          end
        endcase
      end
      S_REDUCE_TICK: begin
        if (stat.acc_ge_n) begin
          ctl.acc_reduce = 1'b1;
        end else begin
          ctl.scan_from_acc = 1'b1;
          ctl.rd_en         = 1'b1;
          ctl.rd_from_acc   = 1'b1;
          state_next        = S_TICK_LOAD;
        end
      end
      S_REDUCE_WRITE: begin
        if (stat.acc_ge_n) begin
          ctl.acc_reduce = 1'b1;
        end else begin
          ctl.wr_glyph = 1'b1;
          state_next   = S_FINISH;
        end
      end
      S_TICK_LOAD: begin
        ctl.latch_drive = 1'b1;
        state_next      = S_FINISH;
      end
      S_CLEAR: begin
        if (stat.clr_done) begin
          state_next = S_FINISH;
        end else begin
          ctl.clr_step = 1'b1;
        end
      end
      S_DOT: begin
        ctl.wr_dot = 1'b1;
        state_next = S_FINISH;
      end
      S_FINISH: begin
        if (stat.out_free) begin
          ctl.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// ===== hw/rtl/ssmd_datapath.sv =====
module ssmd_datapath
  import ssmd_pkg::*;
#(
  parameter int MAX_DIGITS = 8
) (
  input  logic                  clk,
  input  logic                  rst,
  input  cmd_item_t             cmd,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  dp_cmd_t               ctl,
  output dp_stat_t              stat,
  output logic                  disp_valid,
  input  logic                  disp_stall,
  output drive_item_t           disp
);

  localparam int IDX_W = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
  localparam logic [COUNT_W-1:0] MAX_CNT = COUNT_W'(MAX_DIGITS);
  // Reciprocal for the position reduction: floor(p * RECIP / 2^16) equals
  // p / MAX_DIGITS exactly for every 8-bit p.
  localparam int RECIP_W = 18;
  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'((65536 / MAX_DIGITS) + 1);
  localparam int PROD_W = POS_W + RECIP_W;

  cmd_item_t            item;
  logic [COUNT_W-1:0]   digit_count;
  logic                 common_cathode;
  logic [COUNT_W-1:0]   acc;
  logic [COUNT_W-1:0]   clr_cnt;
  logic [IDX_W-1:0]     write_position;
  logic [IDX_W-1:0]     scan_index;
  logic [SEG_W-1:0]     segment_register;
  logic [EN_W-1:0]      enable_register;
  logic [SEG_W-1:0]     digit_store [MAX_DIGITS];
  logic [MAX_DIGITS-1:0] store_valid;
  logic [SEG_W-1:0]     rdata;

  logic [COUNT_W-1:0]   active_n;
  logic [PROD_W-1:0]    pos_prod;
  logic [POS_W-1:0]     pos_quot;
  logic [POS_W-1:0]     pos_rem;
  logic                 wr_en;
  logic [IDX_W-1:0]     wr_addr;
  logic [SEG_W-1:0]     wr_data;
  logic [IDX_W-1:0]     rd_addr;
  logic [SEG_W-1:0]     glyph;
  logic [EN_W-1:0]      scan_bit;

  assign cfg_ready = 1'b1;
  assign active_n  = (digit_count > MAX_CNT) ? MAX_CNT : digit_count;

  assign pos_prod = PROD_W'(item.new_position) * PROD_W'(RECIP);
  assign pos_quot = pos_prod[16 +: POS_W];
  assign pos_rem  = item.new_position - POS_W'(pos_quot * POS_W'(MAX_DIGITS));

  assign glyph    = glyph_of(item.char_code);
  assign scan_bit = EN_W'(1) << scan_index;
  assign rd_addr  = ctl.rd_from_acc ? acc[IDX_W-1:0] : write_position;

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = clr_cnt[IDX_W-1:0];
    wr_data = common_cathode ? SEG_BLANK_CATHODE : SEG_BLANK_ANODE;
    if (ctl.wr_glyph) begin
      wr_en   = 1'b1;
      wr_addr = acc[IDX_W-1:0];
      wr_data = common_cathode ? ~glyph : glyph;
    end else if (ctl.wr_dot) begin
      wr_en   = 1'b1;
      wr_addr = write_position;
      wr_data = {common_cathode ^ item.dot_on, rdata[SEG_W-2:0]};
    end else if (ctl.clr_step) begin
      wr_en   = 1'b1;
    end
  end

  assign stat.mode     = item.mode;
  assign stat.n_zero   = (active_n == '0);
  assign stat.acc_ge_n = (acc >= active_n);
  assign stat.clr_done = (clr_cnt >= active_n);
  assign stat.out_free = !disp_valid || !disp_stall;

  // Digit store: one write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      digit_store[wr_addr] <= wr_data;
    end
    if (ctl.rd_en) begin
      rdata <= store_valid[rd_addr] ? digit_store[rd_addr] : SEG_BLANK_ANODE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      store_valid <= '0;
    end else if (wr_en) begin
      store_valid[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.take_item) begin
      item <= cmd;
    end
    if (ctl.acc_load_scan) begin
      acc <= COUNT_W'(scan_index) + COUNT_W'(1);
    end else if (ctl.acc_load_write) begin
      acc <= COUNT_W'(item.char_offset) + COUNT_W'(write_position);
    end else if (ctl.acc_reduce) begin
      acc <= acc - active_n;
    end
    if (ctl.clr_start) begin
      clr_cnt <= '0;
    end else if (ctl.clr_step) begin
      clr_cnt <= clr_cnt + COUNT_W'(1);
    end
    if (ctl.load_out) begin
      disp.segment_lines <= segment_register;
      disp.digit_enables <= enable_register;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      digit_count      <= DIGIT_COUNT_RESET;
      common_cathode   <= 1'b0;
      write_position   <= '0;
      scan_index       <= '0;
      segment_register <= SEG_BLANK_ANODE;
      enable_register  <= EN_ALL_INACTIVE_ANODE;
      disp_valid       <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_DIGIT_COUNT:    digit_count    <= cfg_data;
          CFG_COMMON_CATHODE: common_cathode <= cfg_data[0];
          default: begin
          end
        endcase
      end
      if (ctl.set_pos) begin
        write_position <= pos_rem[IDX_W-1:0];
      end else if (ctl.clr_start) begin
        write_position <= '0;
      end
      if (ctl.scan_from_acc) begin
        scan_index <= acc[IDX_W-1:0];
      end
      if (ctl.latch_drive) begin
        segment_register <= rdata;
        enable_register  <= common_cathode ? scan_bit : ~scan_bit;
      end
      if (ctl.load_out) begin
        disp_valid <= 1'b1;
      end else if (!disp_stall) begin
        disp_valid <= 1'b0;
      end
    end
  end

endmodule

// ===== hw/rtl/seven_segment_mux_display_core.sv =====
// Channel   Direction  Handshake          Carries
// cmd       in         cmd_valid/stall    one command item (cmd_item_t)
// disp      out        disp_valid/stall   segment and enable drive (drive_item_t)
// cfg       in         cfg_valid/ready    register index and write data
//
// Every command item gives exactly one drive item. Each passes from a decode
// state to a finish state: set position goes straight there, a dot reads the
// digit and writes it back, a write subtracts the digit count once per wrap
// step, then writes the glyph, a tick does the same reduction, reads the digit
// and latches the drive, and a clear writes one digit in use per step, as the
// digit store has one write port. The longest case is a write that wraps
// fourteen times on a one-digit display. Reset is synchronous and leaves the
// store blank, the enables inactive and the digit count at eight. The output
// register lets a new command be taken while the previous drive item is still
// stalled; a further item then waits in its finish state until that one leaves.
module seven_segment_mux_display_core
  import ssmd_pkg::*;
#(
  parameter int MAX_DIGITS = 8
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cmd_valid,
  output logic                  cmd_stall,
  input  cmd_item_t             cmd,
  output logic                  disp_valid,
  input  logic                  disp_stall,
  output drive_item_t           disp,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  dp_cmd_t  ctl;
  dp_stat_t stat;

  // The controller sequences each command; the datapath holds the digit
  // store, the configuration and the scan and write positions.
  ssmd_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .stat      (stat),
    .ctl       (ctl)
  );

  ssmd_datapath #(
    .MAX_DIGITS (MAX_DIGITS)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .ctl        (ctl),
    .stat       (stat),
    .disp_valid (disp_valid),
    .disp_stall (disp_stall),
    .disp       (disp)
  );

endmodule
